FILE: design/tfab_pkg.sv
// Shared types and constants for the transform_aabb block.
package tfab_pkg;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned ROW_W   = 3 * COEF_W;
  localparam int unsigned CRN_W   = POS_W + 1;
  localparam int unsigned PROD_W  = CRN_W + COEF_W;
  localparam int unsigned SUM_W   = PROD_W + 2;
  localparam int unsigned FRAC_SH = 12;
  localparam int unsigned BND_W   = SUM_W - FRAC_SH + 1;
  localparam int unsigned HALF_W  = 31;
  localparam int unsigned ADDR_W  = 3;

  localparam logic [ADDR_W-1:0] REG_ROW_X   = 3'd0;
  localparam logic [ADDR_W-1:0] REG_ROW_Y   = 3'd1;
  localparam logic [ADDR_W-1:0] REG_ROW_Z   = 3'd2;
  localparam logic [ADDR_W-1:0] REG_SHIFT_X = 3'd3;
  localparam logic [ADDR_W-1:0] REG_SHIFT_Y = 3'd4;
  localparam logic [ADDR_W-1:0] REG_SHIFT_Z = 3'd5;

  localparam logic [ROW_W-1:0] ROW_X_RST = 48'h0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW_Y_RST = 48'h0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW_Z_RST = 48'h1000_0000_0000;

  typedef logic signed [CRN_W-1:0] tfab_crn_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row_x;
    logic [ROW_W-1:0]        row_y;
    logic [ROW_W-1:0]        row_z;
    logic signed [POS_W-1:0] shift_x;
    logic signed [POS_W-1:0] shift_y;
    logic signed [POS_W-1:0] shift_z;
  } tfab_cfg_t;

  typedef struct packed {
    logic prod;
    logic ext;
    logic bnd;
    logic res;
  } tfab_adv_t;

endpackage

FILE: design/tfab_regs.sv
// Configuration register file: three matrix rows and the translation.
module tfab_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tfab_pkg::ADDR_W-1:0]         cfg_addr,
  input  logic [tfab_pkg::ROW_W-1:0]          cfg_data,
  output tfab_pkg::tfab_cfg_t                 cfg
);
  import tfab_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_x   <= ROW_X_RST;
      cfg.row_y   <= ROW_Y_RST;
      cfg.row_z   <= ROW_Z_RST;
      cfg.shift_x <= '0;
      cfg.shift_y <= '0;
      cfg.shift_z <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROW_X:   cfg.row_x   <= cfg_data;
        REG_ROW_Y:   cfg.row_y   <= cfg_data;
        REG_ROW_Z:   cfg.row_z   <= cfg_data;
        REG_SHIFT_X: cfg.shift_x <= signed'(cfg_data[POS_W-1:0]);
        REG_SHIFT_Y: cfg.shift_y <= signed'(cfg_data[POS_W-1:0]);
        REG_SHIFT_Z: cfg.shift_z <= signed'(cfg_data[POS_W-1:0]);
        default: ;
      endcase
    end
  end

endmodule

FILE: design/tfab_axis.sv
// One output axis: products, per-term min/max, bound sums, center and half extent.
module tfab_axis (
  input  logic                              clk,
  input  tfab_pkg::tfab_adv_t               adv,
  input  logic [tfab_pkg::ROW_W-1:0]        row,
  input  logic signed [tfab_pkg::POS_W-1:0] shift,
  input  tfab_pkg::tfab_crn_t               base [3],
  input  tfab_pkg::tfab_crn_t               far  [3],
  output logic signed [tfab_pkg::POS_W-1:0] center,
  output logic [tfab_pkg::HALF_W-1:0]       half
);
  import tfab_pkg::*;

  localparam logic signed [BND_W-1:0] CTR_MAX  = BND_W'(64'sd2147483647);
  localparam logic signed [BND_W-1:0] CTR_MIN  = BND_W'(-64'sd2147483648);
  localparam logic signed [BND_W-1:0] HALF_MAX = BND_W'(64'sd2147483647);

  logic signed [PROD_W-1:0] prod_a [3];
  logic signed [PROD_W-1:0] prod_b [3];
  logic signed [PROD_W-1:0] ext_lo [3];
  logic signed [PROD_W-1:0] ext_hi [3];
  logic signed [SUM_W-1:0]  sum_lo;
  logic signed [SUM_W-1:0]  sum_hi;
  logic signed [BND_W-1:0]  lo;
  logic signed [BND_W-1:0]  hi;
  logic signed [BND_W:0]    bsum;
  logic signed [BND_W:0]    bdif;
  logic signed [BND_W-1:0]  ctr_w;
  logic signed [BND_W-1:0]  half_w;

  for (genvar j = 0; j < 3; j++) begin : g_term
    logic signed [COEF_W-1:0] coef;
    assign coef = signed'(row[COEF_W*j +: COEF_W]);

    always_ff @(posedge clk) begin
      if (adv.prod) begin
        prod_a[j] <= coef * base[j];
        prod_b[j] <= coef * far[j];
      end
      if (adv.ext) begin
        ext_lo[j] <= (prod_a[j] < prod_b[j]) ? prod_a[j] : prod_b[j];
        ext_hi[j] <= (prod_a[j] < prod_b[j]) ? prod_b[j] : prod_a[j];
      end
    end
  end

  assign sum_lo = SUM_W'(ext_lo[0]) + SUM_W'(ext_lo[1]) + SUM_W'(ext_lo[2]);
  assign sum_hi = SUM_W'(ext_hi[0]) + SUM_W'(ext_hi[1]) + SUM_W'(ext_hi[2]);

  always_ff @(posedge clk) begin
    if (adv.bnd) begin
      lo <= BND_W'(sum_lo >>> FRAC_SH) + BND_W'(shift);
      hi <= BND_W'(sum_hi >>> FRAC_SH) + BND_W'(shift);
    end
  end

  assign bsum   = (BND_W+1)'(hi) + (BND_W+1)'(lo);
  assign bdif   = (BND_W+1)'(hi) - (BND_W+1)'(lo);
  assign ctr_w  = BND_W'(bsum >>> 1);
  assign half_w = BND_W'(bdif >>> 1);

  always_ff @(posedge clk) begin
    if (adv.res) begin
      if (ctr_w > CTR_MAX) begin
        center <= CTR_MAX[POS_W-1:0];
      end else if (ctr_w < CTR_MIN) begin
        center <= CTR_MIN[POS_W-1:0];
      end else begin
        center <= ctr_w[POS_W-1:0];
      end
      if (half_w > HALF_MAX) begin
        half <= HALF_MAX[HALF_W-1:0];
      end else if (half_w < 0) begin
        half <= '0;
      end else begin
        half <= half_w[HALF_W-1:0];
      end
    end
  end

endmodule

FILE: design/transform_aabb_top.sv
// Top level of the transform_aabb block: stream ports, corner stage, pipeline control.
//
// Usage: s_* carries one local box per beat (origin corner and size, Q16.16);
// m_* returns its world-space box as center and half extents, Q16.16 with
// saturation. The cfg_* port writes the three Q4.12 matrix rows (index 0..2)
// and the translation (index 3..5) while no beat is in flight; other indexes
// are ignored. The matrix splits per term, so each axis bound is the sum of
// per-term minima or maxima of two products, then a floor shift and the
// translation.
// Stages: corner add, multiply, min/max, bound sum, center/half with saturation.
// Throughput: one beat per cycle unless the receiver stalls, set by the five-stage
// register pipeline.
// Reset clears all stage valid bits and loads the identity matrix and zero
// translation. When the receiver stalls, the output beat holds and each
// stage keeps taking beats until it is full; then s_tready drops.
module transform_aabb_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // corner_x[31:0], corner_y[63:32], corner_z[95:64],
  // extent_x[127:96], extent_y[159:128], extent_z[191:160]
  input  logic [191:0]                      s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // center_x[31:0], center_y[63:32], center_z[95:64],
  // half_x[126:96], half_y[157:127], half_z[188:158], zero[191:189]
  output logic [191:0]                      m_tdata,
  input  logic                              cfg_we,
  input  logic [tfab_pkg::ADDR_W-1:0]       cfg_addr,
  input  logic [tfab_pkg::ROW_W-1:0]        cfg_data
);
  import tfab_pkg::*;

  localparam int unsigned NSTG = 5;

  tfab_cfg_t                cfg;
  tfab_adv_t                adv;
  logic [NSTG:1]            vld;
  logic [NSTG:1]            rdy;
  tfab_crn_t                base [3];
  tfab_crn_t                far  [3];
  logic signed [POS_W-1:0]  center [3];
  logic [HALF_W-1:0]        half   [3];
  logic [ROW_W-1:0]         rows   [3];
  logic signed [POS_W-1:0]  shifts [3];

  tfab_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  assign rows[0]   = cfg.row_x;
  assign rows[1]   = cfg.row_y;
  assign rows[2]   = cfg.row_z;
  assign shifts[0] = cfg.shift_x;
  assign shifts[1] = cfg.shift_y;
  assign shifts[2] = cfg.shift_z;

  assign rdy[NSTG] = !vld[NSTG] || m_tready;
  for (genvar k = 1; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  assign s_tready = rdy[1];
  assign adv.prod = rdy[2];
  assign adv.ext  = rdy[3];
  assign adv.bnd  = rdy[4];
  assign adv.res  = rdy[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [POS_W-1:0] org;
    logic signed [POS_W-1:0] ext;
    assign org = signed'(s_tdata[POS_W*a +: POS_W]);
    assign ext = signed'(s_tdata[POS_W*(a+3) +: POS_W]);

    always_ff @(posedge clk) begin
      if (rdy[1]) begin
        base[a] <= CRN_W'(org);
        far[a]  <= CRN_W'(org) + CRN_W'(ext);
      end
    end

    tfab_axis u_axis (
      .clk    (clk),
      .adv    (adv),
      .row    (rows[a]),
      .shift  (shifts[a]),
      .base   (base),
      .far    (far),
      .center (center[a]),
      .half   (half[a])
    );
  end

  assign m_tvalid = vld[NSTG];
  assign m_tdata  = {3'b000, half[2], half[1], half[0], center[2], center[1], center[0]};

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[1])
    else $error("accepted beat not held in first stage");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (&vld && !m_tready) |-> !s_tready)
    else $error("input taken while pipeline full and stalled");

  a_bubble_admits: assert property (@(posedge clk) disable iff (rst)
    (vld != '1) |-> s_tready)
    else $error("input refused while a stage is empty");

endmodule

FILE: bench/tb.sv
// Testbench for transform_aabb_top: directed and random boxes checked against a fixed-point model.
`timescale 1ns / 1ps

module tb;
  import tfab_pkg::*;

  localparam int LAT = 5;
  localparam int WATCH_LIMIT = 2000;
  localparam int PHASES = 10;
  localparam int RAND_PER_PHASE = 141;
  localparam int BACKLOG_AT = 300;
  localparam int BACKLOG_LEN = 64;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam logic [ADDR_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [POS_W-1:0] ext_z, ext_y, ext_x, crn_z, crn_y, crn_x;
  } box_t;

  typedef struct packed {
    logic [2:0]              pad;
    logic [HALF_W-1:0]       half_z, half_y, half_x;
    logic signed [POS_W-1:0] ctr_z, ctr_y, ctr_x;
  } res_t;

  typedef struct {
    box_t box;
    bit   typed;
    res_t want;
  } probe_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [191:0]       s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [191:0]       m_tdata;
  logic               cfg_we = 1'b0;
  logic [ADDR_W-1:0]  cfg_addr = '0;
  logic [ROW_W-1:0]   cfg_data = '0;

  logic [ROW_W-1:0]        row_m [3];
  logic signed [POS_W-1:0] shift_m [3];
  res_t                    world_box_q [$];
  probe_t                  probe_tab [$];
  int                      err_cnt = 0;
  int                      rx_beats = 0;
  int                      rx_stall = 0;
  int                      idle_cyc = 0;
  bit                      backlog_done = 1'b0;
  bit                      quiet_tail = 1'b0;

  always #6 clk = ~clk;

  transform_aabb_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  function automatic res_t world_box_of(box_t b);
    longint org [3];
    longint ext [3];
    longint far_c [3];
    longint lo [3];
    longint hi [3];
    longint p [3];
    longint ctr [3];
    longint half [3];
    longint acc, v, coef;
    int a, j, c;
    res_t r;
    org[0] = b.crn_x;
    org[1] = b.crn_y;
    org[2] = b.crn_z;
    ext[0] = b.ext_x;
    ext[1] = b.ext_y;
    ext[2] = b.ext_z;
    for (a = 0; a < 3; a++) far_c[a] = org[a] + ext[a];
    for (c = 0; c < 8; c++) begin
      for (j = 0; j < 3; j++) p[j] = ((c >> j) & 1) ? far_c[j] : org[j];
      for (a = 0; a < 3; a++) begin
        acc = 0;
        for (j = 0; j < 3; j++) begin
          coef = $signed(row_m[a][16*j +: 16]);
          acc += coef * p[j];
        end
        v = (acc >>> FRAC_SH) + longint'(shift_m[a]);
        if (c == 0 || v < lo[a]) lo[a] = v;
        if (c == 0 || v > hi[a]) hi[a] = v;
      end
    end
    for (a = 0; a < 3; a++) begin
      ctr[a] = (hi[a] + lo[a]) >>> 1;
      half[a] = (hi[a] - lo[a]) >>> 1;
      if (ctr[a] > POS_MAX) ctr[a] = POS_MAX;
      if (ctr[a] < POS_MIN) ctr[a] = POS_MIN;
      if (half[a] > POS_MAX) half[a] = POS_MAX;
      if (half[a] < 0) half[a] = 0;
    end
    r = '0;
    r.ctr_x = ctr[0][31:0];
    r.ctr_y = ctr[1][31:0];
    r.ctr_z = ctr[2][31:0];
    r.half_x = half[0][30:0];
    r.half_y = half[1][30:0];
    r.half_z = half[2][30:0];
    return r;
  endfunction

  function automatic box_t mk_box(logic [31:0] cx, cy, cz, ex, ey, ez);
    box_t b;
    b.crn_x = cx;
    b.crn_y = cy;
    b.crn_z = cz;
    b.ext_x = ex;
    b.ext_y = ey;
    b.ext_z = ez;
    return b;
  endfunction

  function automatic res_t mk_res(logic [31:0] cx, cy, cz, logic [30:0] hx, hy, hz);
    res_t r;
    r = '0;
    r.ctr_x = cx;
    r.ctr_y = cy;
    r.ctr_z = cz;
    r.half_x = hx;
    r.half_y = hy;
    r.half_z = hz;
    return r;
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4: return 16'($urandom_range(0, 8192)) - 16'd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic box_t rand_box();
    return mk_box(rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_pos());
  endfunction

  task automatic cmp_field(string tag, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, tag, want, got);
    end
  endtask

  task automatic check_beat(res_t got);
    res_t want;
    if (world_box_q.size() == 0) begin
      err_cnt++;
      $display("%0t: result beat with nothing pending, expected none, got %h", $time, got);
    end else begin
      want = world_box_q.pop_front();
      cmp_field("center_x", want.ctr_x, got.ctr_x);
      cmp_field("center_y", want.ctr_y, got.ctr_y);
      cmp_field("center_z", want.ctr_z, got.ctr_z);
      cmp_field("half_x", 32'(want.half_x), 32'(got.half_x));
      cmp_field("half_y", 32'(want.half_y), 32'(got.half_y));
      cmp_field("half_z", 32'(want.half_z), 32'(got.half_z));
      cmp_field("pad", 32'(want.pad), 32'(got.pad));
    end
  endtask

  // receive side: check beats, then pick next tready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_beat(res_t'(m_tdata));
        rx_beats++;
      end
      if (rx_stall != 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else if (!backlog_done && rx_beats >= BACKLOG_AT && s_tvalid) begin
        backlog_done = 1'b1;
        rx_stall = BACKLOG_LEN - 1;
        m_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        rx_stall = $urandom_range(0, 4);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WATCH_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  task automatic send_box(box_t b, res_t want);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    world_box_q.push_back(want);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (world_box_q.size() != 0) @(posedge clk);
    repeat (LAT + 3) @(posedge clk);
  endtask

  task automatic cfg_write(logic [ADDR_W-1:0] idx, logic [ROW_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_ROW_X:   row_m[0] = val;
      REG_ROW_Y:   row_m[1] = val;
      REG_ROW_Z:   row_m[2] = val;
      REG_SHIFT_X: shift_m[0] = val[31:0];
      REG_SHIFT_Y: shift_m[1] = val[31:0];
      REG_SHIFT_Z: shift_m[2] = val[31:0];
      default: ;
    endcase
  endtask

  task automatic load_phase(int ph);
    logic [15:0] cf;
    logic [ROW_W-1:0] rows [3];
    logic [31:0] shs [3];
    int a;
    for (a = 0; a < 3; a++) begin
      case (ph)
        1: begin
          cf = 16'h7FFF;
          rows[a] = {cf, cf, cf};
          shs[a] = 32'h7FFF_FFFF;
        end
        2: begin
          cf = 16'h8000;
          rows[a] = {cf, cf, cf};
          shs[a] = 32'h8000_0000;
        end
        3: begin
          rows[a] = '0;
          shs[a] = rand_pos();
        end
        default: begin
          rows[a] = {rand_coef(), rand_coef(), rand_coef()};
          shs[a] = rand_pos();
        end
      endcase
    end
    cfg_write(REG_ROW_X, rows[0]);
    cfg_write(REG_SPARE_LO, {$urandom, 16'($urandom)});
    cfg_write(REG_ROW_Y, rows[1]);
    cfg_write(REG_ROW_Z, rows[2]);
    cfg_write(REG_SHIFT_X, {16'($urandom), shs[0]});
    cfg_write(REG_SHIFT_Y, {16'($urandom), shs[1]});
    cfg_write(REG_SPARE_HI, {$urandom, 16'($urandom)});
    cfg_write(REG_SHIFT_Z, {16'($urandom), shs[2]});
    cfg_we <= 1'b0;
  endtask

  initial begin
    int ph, k;
    box_t b;
    row_m[0] = ROW_X_RST;
    row_m[1] = ROW_Y_RST;
    row_m[2] = ROW_Z_RST;
    for (k = 0; k < 3; k++) shift_m[k] = '0;

    probe_tab.push_back('{mk_box(0, 0, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0, 0, 0)});
    probe_tab.push_back('{mk_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b1,
                          mk_res(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 31'h3FFF_FFFF, 31'h3FFF_FFFF, 31'h3FFF_FFFF)});
    probe_tab.push_back('{mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b1,
                          mk_res(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 31'h4000_0000, 31'h4000_0000, 31'h4000_0000)});
    probe_tab.push_back('{mk_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b1,
                          mk_res(32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h3FFF_FFFF,
                                 31'h4000_0000, 31'h4000_0000, 31'h4000_0000)});
    probe_tab.push_back('{mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b1,
                          mk_res(32'hBFFF_FFFF, 32'hBFFF_FFFF, 32'hBFFF_FFFF,
                                 31'h3FFF_FFFF, 31'h3FFF_FFFF, 31'h3FFF_FFFF)});
    probe_tab.push_back('{mk_box(32'h000A_0000, 32'h000A_0000, 32'h000A_0000,
                                 32'hFFFC_0000, 32'hFFFC_0000, 32'hFFFC_0000), 1'b1,
                          mk_res(32'h0008_0000, 32'h0008_0000, 32'h0008_0000,
                                 31'h0002_0000, 31'h0002_0000, 31'h0002_0000)});
    probe_tab.push_back('{mk_box(0, 32'hFFFF_FFFF, 3, 1, 0, 32'hFFFF_FFFE), 1'b1,
                          mk_res(0, 32'hFFFF_FFFF, 2, 0, 0, 1)});
    probe_tab.push_back('{mk_box(32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'h0F0F_F0F0,
                                 32'hF0F0_0F0F, 32'h3C3C_C3C3, 32'hC3C3_3C3C), 1'b0, '0});
    probe_tab.push_back('{mk_box(32'h0001_8000, 32'hFFFE_8000, 32'h7FFF_0000,
                                 32'h8001_0000, 32'h0000_0001, 32'hFFFF_FFFF), 1'b0, '0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        drain();
        load_phase(ph);
      end
      if (ph == PHASES - 1) quiet_tail = 1'b1;
      foreach (probe_tab[k])
        send_box(probe_tab[k].box, (ph == 0 && probe_tab[k].typed) ? probe_tab[k].want
                                                                    : world_box_of(probe_tab[k].box));
      for (k = 0; k < RAND_PER_PHASE; k++) begin
        b = rand_box();
        send_box(b, world_box_of(b));
      end
    end
    drain();

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
